// ===== rtl/core/sid_pkg.sv =====
// Shared types and codes for the sorted identifier table.
package sid_pkg;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   localparam int ENTRY_COUNT_BITS = 7;
   localparam int REQ_ID_BITS      = 16;

   // compare results that a cell hands to its right-hand neighbour
   typedef struct packed {
      logic gt;
      logic ge;
      logic hit;
   } cell_flags_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cell_cmd_type;

endpackage

// ===== rtl/core/sid_cell.sv =====
// One slot of the sorted table: compare against the key, shift left or right.
module sid_cell #(
   parameter int ID_BITS = 16
) (
   input  logic                    clock,
   input  logic                    valid,
   input  logic [ID_BITS-1:0]      key,
   input  sid_pkg::cell_cmd_type   cmd,
   input  sid_pkg::cell_flags_type left_flags,
   input  logic [ID_BITS-1:0]      left_entry,
   input  logic [ID_BITS-1:0]      right_entry,
   output sid_pkg::cell_flags_type flags,
   output logic [ID_BITS-1:0]      entry
);

   logic [ID_BITS-1:0] entry_ff;
   logic [ID_BITS-1:0] entry_in;

   // empty slots act as greater than any key
   always_comb begin
      flags.gt  = !valid || (entry_ff > key);
      flags.ge  = !valid || (entry_ff >= key);
      flags.hit = valid && (entry_ff == key) && !left_flags.ge;
   end

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.insert_en && flags.gt) begin
         entry_in = left_flags.gt ? left_entry : key;
      end else if (cmd.remove_en && flags.ge) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/sorted_id_table.sv =====
// Top level: sorted identifier table built from a row of compare-and-shift cells.
//
// Requests arrive on the req_ stream: req_tuser carries the kind (insert or
// remove) and req_tdata the identifier. Every request yields one response on
// the rsp_ stream with a status code and the number of entries held after it.
// All cells compare the identifier against their entry in the cycle the request
// is taken and shift in the same edge, so the response is registered in the cycle
// after acceptance; one request is taken per cycle unless a held response stalls
// the input. The cell compare and the hit reduction across the row set that figure.
// An insert goes after any equal entries; a remove drops the first equal one.
// A full table rejects an insert with a full status; removing an absent
// identifier returns a not-found status. Neither changes the table.
// Reset empties the table (the count goes to zero; cell contents are left as
// they are and are never read while empty) and drops any pending response.
// When the receiver holds rsp_tready low the response waits in its register
// and req_tready falls until it is taken; it rises again in the same cycle
// the response leaves.
module sorted_id_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] entity_id
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [8:2] entry_count, [15:9] zero
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EB = sid_pkg::ENTRY_COUNT_BITS;

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     rsp_tvalid_ff;
   logic                     rsp_tvalid_in;
   sid_pkg::status_type      status_ff;
   sid_pkg::status_type      status_in;
   logic [EB-1:0]            entry_count_ff;
   logic [EB-1:0]            entry_count_in;

   logic                     accept;
   logic                     is_insert;
   logic                     full;
   logic                     found;
   logic [ID_BITS-1:0]       key;
   sid_pkg::cell_cmd_type    cmd;

   sid_pkg::cell_flags_type  flags [TABLE_DEPTH];
   logic [ID_BITS-1:0]       entries [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   hit_vec;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_insert  = (sid_pkg::kind_type'(req_tuser[0]) == sid_pkg::KIND_INSERT);
   assign full       = (count_ff == CW'(TABLE_DEPTH));

   generate
      if (ID_BITS <= sid_pkg::REQ_ID_BITS) begin : g_key_narrow
         assign key = req_tdata[ID_BITS-1:0];
      end else begin : g_key_wide
         assign key = {{(ID_BITS - sid_pkg::REQ_ID_BITS){1'b0}}, req_tdata};
      end
   endgenerate

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         sid_pkg::cell_flags_type left_flags;
         logic [ID_BITS-1:0]      left_entry;
         logic [ID_BITS-1:0]      right_entry;

         if (i == 0) begin : g_first
            assign left_flags = '0;
            assign left_entry = key;
         end else begin : g_mid
            assign left_flags = flags[i-1];
            assign left_entry = entries[i-1];
         end

         if (i == TABLE_DEPTH - 1) begin : g_last
            assign right_entry = entries[i];
         end else begin : g_inner
            assign right_entry = entries[i+1];
         end

         sid_cell #(
            .ID_BITS (ID_BITS)
         ) u_cell (
            .clock       (clock),
            .valid       (count_ff > CW'(i)),
            .key         (key),
            .cmd         (cmd),
            .left_flags  (left_flags),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .flags       (flags[i]),
            .entry       (entries[i])
         );

         assign hit_vec[i] = flags[i].hit;
      end
   endgenerate

   assign found = |hit_vec;

   always_comb begin
      cmd.insert_en = accept && is_insert && !full;
      cmd.remove_en = accept && !is_insert && found;
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (accept) begin
         priority if (is_insert) begin
            if (full) begin
               status_in = sid_pkg::ST_FULL;
            end else begin
               status_in = sid_pkg::ST_DONE;
               count_in  = count_ff + CW'(1);
            end
         end else begin
            if (found) begin
               status_in = sid_pkg::ST_DONE;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = sid_pkg::ST_MISSING;
            end
         end
      end
   end

   generate
      if (CW >= EB) begin : g_cnt_trunc
         assign entry_count_in = accept ? count_in[EB-1:0] : entry_count_ff;
      end else begin : g_cnt_ext
         assign entry_count_in = accept ? {{(EB - CW){1'b0}}, count_in} : entry_count_ff;
      end
   endgenerate

   assign rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      entry_count_ff <= entry_count_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(16 - EB - 2){1'b0}}, entry_count_ff, status_ff};

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_full_reject : assert property (@(posedge clock) disable iff (reset)
      accept && is_insert && full |=> rsp_tvalid && status_ff == sid_pkg::ST_FULL
         && count_ff == $past(count_ff))
      else $error("insert into full table changed state");

   a_single_hit : assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell claims the remove");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      accept && is_insert && !full |=> count_ff == $past(count_ff) + CW'(1)
         && status_ff == sid_pkg::ST_DONE)
      else $error("insert did not advance entry count");

endmodule
